>>> sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Value of the modulus register after reset.
    localparam int unsigned MODULUS_RESET = 2;

    // Command from the sequencer to the modular multiplier.
    typedef struct packed {
        logic start;
    } t_mul_ctl;

    // Status from the modular multiplier back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

`default_nettype wire

>>> sv/mexp_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for requests, results and modulus writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface mexp_cfg_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Bit-serial shift-and-add multiplier that computes x * y mod m, one bit of
// y per cycle from the most significant bit down, reducing after each step.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod import mexp_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mul_ctl         i_ctl,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_modulus,
    output t_mul_stat             o_stat,
    output logic      [WIDTH-1:0] o_result
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;

    logic [WIDTH+1:0] w_sum;
    logic [WIDTH+1:0] w_m1;
    logic [WIDTH+1:0] w_m2;
    logic [WIDTH+1:0] w_sub1;
    logic [WIDTH+1:0] w_sub2;
    logic [WIDTH-1:0] n_acc;

    // The running value is below the modulus, so the sum stays below three
    // times the modulus and one of three candidates is the reduced value.
    always_comb begin
        w_sum  = {1'b0, r_acc, 1'b0} + (r_y[WIDTH-1] ? {2'b00, r_x} : '0);
        w_m1   = {2'b00, i_modulus};
        w_m2   = {1'b0, i_modulus, 1'b0};
        w_sub1 = w_sum - w_m1;
        w_sub2 = w_sum - w_m2;
        if (w_sum >= w_m2) begin
            n_acc = w_sub2[WIDTH-1:0];
        end else if (w_sum >= w_m1) begin
            n_acc = w_sub1[WIDTH-1:0];
        end else begin
            n_acc = w_sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= {r_y[WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

endmodule

`default_nettype wire

>>> sv/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// Reduces the base, then walks the exponent from its top bit, issuing a
// square and, for set bits, a multiply by the base to the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl import mexp_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [WIDTH-1:0] i_modulus,
    mexp_in_if.sink               i_in,
    mexp_out_if.source            o_out,
    output t_mul_ctl              o_mul_ctl,
    output logic      [WIDTH-1:0] o_mul_x,
    output logic      [WIDTH-1:0] o_mul_y,
    input  wire t_mul_stat        i_mul_stat,
    input  wire logic [WIDTH-1:0] i_mul_result
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic             r_start;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_result;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [CNT_W-1:0] r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_exp   <= i_in.exponent;
                        r_acc   <= (i_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
                        r_x     <= WIDTH'(1);
                        r_y     <= i_in.base;
                        r_bit   <= CNT_W'(WIDTH - 1);
                        r_start <= 1'b1;
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (i_mul_stat.done) begin
                        r_base  <= i_mul_result;
                        r_x     <= r_acc;
                        r_y     <= r_acc;
                        r_start <= 1'b1;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    if (i_mul_stat.done) begin
                        r_acc <= i_mul_result;
                        if (r_exp[r_bit]) begin
                            r_x     <= i_mul_result;
                            r_y     <= r_base;
                            r_start <= 1'b1;
                            r_state <= S_MULT;
                        end else if (r_bit == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_bit   <= r_bit - CNT_W'(1);
                            r_x     <= i_mul_result;
                            r_y     <= i_mul_result;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_MULT: begin
                    if (i_mul_stat.done) begin
                        r_acc <= i_mul_result;
                        if (r_bit == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_bit   <= r_bit - CNT_W'(1);
                            r_x     <= i_mul_result;
                            r_y     <= i_mul_result;
                            r_start <= 1'b1;
                            r_state <= S_SQUARE;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_result    <= (i_modulus == '0) ? '0 : r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE) && !i_mul_stat.busy;
    assign o_out.valid     = r_out_valid;
    assign o_out.result    = r_result;
    assign o_mul_ctl.start = r_start;
    assign o_mul_x         = r_x;
    assign o_mul_y         = r_y;

endmodule

`default_nettype wire

>>> sv/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Computes base ** exponent mod modulus by square-and-multiply on one shared
// bit-serial modular multiplier. The modulus is a single register written
// through the configuration channel; it resets to 2, and a modulus of zero
// gives a result of zero. One request is worked on at a time: the input is
// not ready from acceptance until the result is placed in the output
// register, which holds it while the next request is accepted. Each
// multiplier pass steps through its second operand one bit at a time, and a
// request needs one pass to reduce the base, one squaring pass for every
// exponent bit and one extra pass for every set exponent bit.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top import mexp_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mexp_cfg_if.sink   i_cfg,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);

    logic [WIDTH-1:0] r_modulus;
    t_mul_ctl         w_mul_ctl;
    t_mul_stat        w_mul_stat;
    logic [WIDTH-1:0] w_mul_x;
    logic [WIDTH-1:0] w_mul_y;
    logic [WIDTH-1:0] w_mul_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(MODULUS_RESET);
        end else if (i_cfg.valid) begin
            r_modulus <= i_cfg.data;
        end
    end

    assign i_cfg.ready = 1'b1;

    mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_modulus    (r_modulus),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_mul_ctl    (w_mul_ctl),
        .o_mul_x      (w_mul_x),
        .o_mul_y      (w_mul_y),
        .i_mul_stat   (w_mul_stat),
        .i_mul_result (w_mul_result)
    );

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mul_ctl),
        .i_x       (w_mul_x),
        .i_y       (w_mul_y),
        .i_modulus (r_modulus),
        .o_stat    (w_mul_stat),
        .o_result  (w_mul_result)
    );

endmodule

`default_nettype wire

>>> sv/mexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level checks on the request, result and modulus channels.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker import mexp_pkg::*; #(
    parameter int WIDTH = 16
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cfg_valid,
    input wire logic             i_cfg_ready,
    input wire logic [WIDTH-1:0] i_cfg_data,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [WIDTH-1:0] i_out_result
);

    logic [WIDTH-1:0] r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(MODULUS_RESET);
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_modulus <= i_cfg_data;
        end
    end

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result))
        else $error("result changed while stalled");

    // Only one request is in flight at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    // A result cannot appear right after a request is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // Every result is reduced below the modulus, or zero.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_result == '0) || (i_out_result < r_modulus))
        else $error("result not reduced");

endmodule

bind modular_exponentiation_top mexp_checker #(
    .WIDTH (WIDTH)
) u_mexp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_data   (i_cfg.data),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result)
);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base and exponent requests to the block and checks every result
// against a power-mod predictor kept in step with the modulus register.
// A directed part covers zero and all-ones fields, the exponent-of-one case,
// and the moduli 0, 1, 2 and 65535. Random phases then rewrite the modulus
// between batches, once every pending result has come back. The request and
// result channels both idle and stall at random, except for one calm phase.
// ----------------------------------------------------------------------------

module tb_top;
    import mexp_pkg::*;

    localparam int WIDTH          = 16;
    localparam int PHASE_REQUESTS = 72;
    localparam int RANDOM_PHASES  = 16;
    localparam int IDLE_PERCENT   = 14;
    localparam int SETTLE_CYCLES  = 620;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic [WIDTH-1:0] t_word;

    class exp_scoreboard;
        t_word       modulus;
        t_word       expected_q[$];
        int unsigned n_errors;

        function new();
            modulus  = t_word'(MODULUS_RESET);
            n_errors = 0;
        endfunction

        function void set_modulus(t_word value);
            modulus = value;
        endfunction

        // Right-to-left binary powering with full-width products.
        function t_word power_mod(t_word b, t_word e);
            logic [2*WIDTH-1:0] m;
            logic [2*WIDTH-1:0] acc;
            logic [2*WIDTH-1:0] sq;
            if (modulus == '0) begin
                return '0;
            end
            m   = modulus;
            sq  = b % m;
            acc = 1 % m;
            for (int i = 0; i < WIDTH; i++) begin
                if (e[i]) begin
                    acc = (acc * sq) % m;
                end
                sq = (sq * sq) % m;
            end
            return acc[WIDTH-1:0];
        endfunction

        function void note_request(t_word b, t_word e);
            expected_q.push_back(power_mod(b, e));
        endfunction

        task report(string msg);
            $display("tb_top: mismatch: %s", msg);
            n_errors++;
        endtask

        task check_result(t_word got);
            t_word want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d with no request pending", got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    report($sformatf("result %0d, expected %0d (modulus %0d)",
                                     got, want, modulus));
                end
            end
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    mexp_cfg_if #(.WIDTH(WIDTH)) cfg_if ();
    mexp_in_if  #(.WIDTH(WIDTH)) req_if ();
    mexp_out_if #(.WIDTH(WIDTH)) res_if ();

    exp_scoreboard sb = new();

    modular_exponentiation_top #(
        .WIDTH(WIDTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (req_if),
        .o_out  (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.set_modulus(cfg_if.data);
            end
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.result);
            end
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.base, req_if.exponent);
            end
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cfg_if.valid && cfg_if.ready) || (req_if.valid && req_if.ready) ||
                (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(input t_word b, input t_word e);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.base     <= b;
        req_if.exponent <= e;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(input t_word value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_word pick_base(t_word m);
        case ($urandom_range(9))
            0: return t_word'($urandom_range(3));
            1: return m - t_word'(1);
            2: return m;
            3: return m + t_word'(1);
            4: return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_word pick_exponent();
        case ($urandom_range(9))
            0: return t_word'($urandom_range(3));
            1: return '1;
            2: return t_word'(1) << $urandom_range(WIDTH - 1);
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic run_random_phase(input int count);
        t_word b;
        t_word e;
        for (int i = 0; i < count; i++) begin
            b = pick_base(sb.modulus);
            e = pick_exponent();
            send_request(b, e);
        end
    endtask

    initial begin
        t_word fixed_moduli[6];
        t_word m;
        fixed_moduli = '{16'd65521, 16'd3, 16'd1, 16'd65535, 16'd0, 16'd2};
        steady = 1'b0;
        i_rst_n         <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        req_if.valid    <= 1'b0;
        req_if.base     <= '0;
        req_if.exponent <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Modulus still at its reset value of 2.
        send_request(16'd0, 16'd0);
        send_request(16'd1, 16'd0);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'd3, 16'd1);
        send_request(16'd2, 16'd1);
        send_request(16'hFFFF, 16'd0);
        send_request(16'd0, 16'hFFFF);

        write_modulus(16'hFFFF);
        send_request(16'd0, 16'd0);
        send_request(16'hFFFF, 16'd1);
        send_request(16'hFFFE, 16'd2);
        send_request(16'd2, 16'd16);
        send_request(16'd2, 16'd15);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'd12345, 16'hFFFF);
        send_request(16'd1, 16'd12345);
        send_request(16'hFFFE, 16'hFFFF);

        write_modulus(16'd0);
        send_request(16'd5, 16'd3);
        send_request(16'd0, 16'd0);
        send_request(16'hFFFF, 16'hFFFF);

        write_modulus(16'd1);
        send_request(16'd0, 16'd0);
        send_request(16'd7, 16'd1);
        send_request(16'hFFFF, 16'hFFFF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 6) begin
                m = fixed_moduli[p];
            end else if (p % 2 == 1) begin
                m = t_word'($urandom_range(255, 2));
            end else begin
                m = t_word'($urandom_range(65535, 256));
            end
            write_modulus(m);
            steady = (p == 7);
            run_random_phase(PHASE_REQUESTS);
        end

        drain();
        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/mexp_pkg.sv
sv/mexp_if.sv
sv/mexp_mulmod.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation_top.sv
sv/mexp_checker.sv
verif/tb_top.sv
